@@ hw/rtl/slab_pkg.sv @@
package slab_pkg;

    localparam int unsigned CpusDef       = 4;
    localparam int unsigned BatchDef      = 16;
    localparam int unsigned LimitDef      = 32;
    localparam int unsigned PageBytesDef  = 4096;
    localparam int unsigned FreeDepthDef  = 1024;
    localparam int unsigned HandleBitsDef = 48;

    localparam int unsigned HandleW   = 48;
    localparam int unsigned ObjBytesW = 12;
    localparam int unsigned CpuIdxW   = 8;
    localparam int unsigned FreeOutW  = 11;
    localparam int unsigned MovedW    = 16;

    localparam logic [ObjBytesW-1:0] ObjBytesRst = 12'd32;
    localparam logic [ObjBytesW-1:0] ObjBytesMin = 12'd8;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_NULL = 2'd2,
        ST_OVF  = 2'd3
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

@@ hw/rtl/slab_object_allocator.sv @@
// Slab object cache: per-CPU handle stacks in front of one shared LIFO free stack.
//
// Input channel: i_valid / o_stall. An item is taken at a clock edge where i_valid
// is high and o_stall is low. i_cmd selects allocate or free; i_cpu_index values at
// or above CPUS use CPU 0. Output channel: o_valid / i_stall, one result item for
// every input item, in order. The object size register is written through
// i_cfg_we / i_cfg_data by the user only while idle; the block does not enforce it.
//
// Sequencing: a plain pop or push goes from acceptance through S_FIN to the result
// register (the stack memory read is issued in the accept cycle). A refill moves
// each handle through S_RF_RD and S_RF_WR, a flush through S_FL_RD and S_FL_WR,
// and carving a page writes one object per cycle, all set by the single write
// port of the shared-stack memory and the registered reads of both memories. The
// block works on one item at a time.
//
// Reset clears all stack counts, the moved counter and the output valid flag, and
// sets the object size to 32 bytes; stack memories are not cleared. While the
// receiver stalls, a finished result waits in the output register; the next item
// can still be accepted and worked on, and holds in its final state until the
// output register is free.
module slab_object_allocator
    import slab_pkg::*;
#(
    parameter int unsigned CPUS        = CpusDef,
    parameter int unsigned BATCH       = BatchDef,
    parameter int unsigned LIMIT       = LimitDef,
    parameter int unsigned PAGE_BYTES  = PageBytesDef,
    parameter int unsigned FREE_DEPTH  = FreeDepthDef,
    parameter int unsigned HANDLE_BITS = HandleBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ObjBytesW-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [CpuIdxW-1:0]   i_cpu_index,
    input  logic [HandleW-1:0]   i_obj_handle,
    input  logic [HandleW-1:0]   i_page_base,
    input  logic                 i_page_valid,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [HandleW-1:0]   o_handle,
    output logic [1:0]           o_status,
    output logic                 o_page_taken,
    output logic [FreeOutW-1:0]  o_free_objects,
    output logic [MovedW-1:0]    o_moved_objects
);

    localparam int unsigned CW   = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int unsigned CNW  = $clog2(LIMIT + 1);
    localparam int unsigned AW   = (CPUS * LIMIT > 1) ? $clog2(CPUS * LIMIT) : 1;
    localparam int unsigned SW   = $clog2(FREE_DEPTH + 1);
    localparam int unsigned FAW  = $clog2(FREE_DEPTH);
    localparam int unsigned OW   = $clog2(PAGE_BYTES + 8192);
    localparam int unsigned IW   = $clog2(BATCH + 1);
    localparam int unsigned BMIN = (BATCH < LIMIT) ? BATCH : LIMIT;
    localparam logic [HandleW-1:0] HMASK =
        (HANDLE_BITS >= HandleW) ? {HandleW{1'b1}} : HandleW'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CARVE = 9'b000000010,
        S_RF_RD = 9'b000000100,
        S_RF_WR = 9'b000001000,
        S_FL_RD = 9'b000010000,
        S_FL_WR = 9'b000100000,
        S_PUSH  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

    // Memories.
    logic [HandleW-1:0] cpu_mem [CPUS*LIMIT];
    logic [HandleW-1:0] sh_mem  [FREE_DEPTH];
    logic [HandleW-1:0] r_cpu_rd;
    logic [HandleW-1:0] r_sh_rd;

    logic               cpu_we, cpu_re, sh_we, sh_re;
    logic [AW-1:0]      cpu_wa, cpu_ra;
    logic [HandleW-1:0] cpu_wd, sh_wd;
    logic [FAW-1:0]     sh_wa, sh_ra;

    // Control state.
    t_state             r_state, n_state;
    logic [ObjBytesW-1:0] r_obj_bytes;
    logic [CW-1:0]      r_cpu, n_cpu;
    logic [HandleW-1:0] r_obj, n_obj;
    logic [SW-1:0]      r_sc, n_sc;
    logic [MovedW-1:0]  r_moved, n_moved;
    t_status            r_status, n_status;
    logic               r_taken, n_taken;
    logic [OW-1:0]      r_off, n_off;
    logic [HandleW-1:0] r_addr, n_addr;
    logic [IW-1:0]      r_i, n_i;
    logic               r_use_rd, n_use_rd;
    logic [CNW-1:0]     r_counts [CPUS];

    logic               cnt_we;
    logic [CNW-1:0]     cnt_wd;
    logic [CW-1:0]      cpu_map, cpu_cur;
    logic [CNW-1:0]     cnt_cur;
    logic [AW-1:0]      base;
    logic [ObjBytesW-1:0] sz;
    logic [OW-1:0]      off_nxt;

    // Output register.
    logic               r_ovalid;
    logic [HandleW-1:0] r_ohandle;
    logic [1:0]         r_ostatus;
    logic               r_otaken;
    logic [FreeOutW-1:0] r_ofree;
    logic [MovedW-1:0]  r_omoved;
    logic               fin_load;

    assign cpu_map = ({1'b0, i_cpu_index} >= 9'(CPUS)) ? '0 : CW'(i_cpu_index);
    assign cpu_cur = (r_state == S_IDLE) ? cpu_map : r_cpu;
    assign cnt_cur = r_counts[cpu_cur];
    assign base    = AW'(int'(cpu_cur) * int'(LIMIT));
    assign sz      = (r_obj_bytes < ObjBytesMin) ? ObjBytesMin : r_obj_bytes;
    assign off_nxt = r_off + OW'(sz);
    assign fin_load = (r_state == S_FIN) && (!r_ovalid || !i_stall);
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cpu    = r_cpu;
        n_obj    = r_obj;
        n_sc     = r_sc;
        n_moved  = r_moved;
        n_status = r_status;
        n_taken  = r_taken;
        n_off    = r_off;
        n_addr   = r_addr;
        n_i      = r_i;
        n_use_rd = r_use_rd;
        cnt_we   = 1'b0;
        cnt_wd   = cnt_cur;
        cpu_we   = 1'b0;
        cpu_wa   = base + AW'(cnt_cur);
        cpu_wd   = r_obj;
        cpu_re   = 1'b0;
        cpu_ra   = base + AW'(cnt_cur) - AW'(1);
        sh_we    = 1'b0;
        sh_wa    = FAW'(r_sc);
        sh_wd    = r_addr;
        sh_re    = 1'b0;
        sh_ra    = FAW'(r_sc - SW'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cpu    = cpu_map;
                    n_obj    = i_obj_handle;
                    n_status = ST_OK;
                    n_taken  = 1'b0;
                    n_use_rd = 1'b0;
                    n_i      = '0;
                    n_off    = '0;
                    n_addr   = i_page_base;
                    if (i_cmd == CMD_ALLOC) begin
                        if (cnt_cur != '0) begin
                            // Fast pop: read the top handle now.
                            cpu_re   = 1'b1;
                            cnt_we   = 1'b1;
                            cnt_wd   = cnt_cur - CNW'(1);
                            n_use_rd = 1'b1;
                            n_state  = S_FIN;
                        end else if (r_sc == '0 && i_page_valid &&
                                     OW'(sz) <= OW'(PAGE_BYTES)) begin
                            n_taken = 1'b1;
                            n_state = S_CARVE;
                        end else begin
                            n_state = S_RF_RD;
                        end
                    end else begin
                        if (i_obj_handle == '0) begin
                            n_status = ST_NULL;
                            n_state  = S_FIN;
                        end else if (cnt_cur < CNW'(LIMIT)) begin
                            cpu_we  = 1'b1;
                            cpu_wd  = i_obj_handle;
                            cnt_we  = 1'b1;
                            cnt_wd  = cnt_cur + CNW'(1);
                            n_state = S_FIN;
                        end else begin
                            n_state = S_FL_RD;
                        end
                    end
                end
            end
            S_CARVE: begin
                // One object per cycle, ascending addresses.
                if (r_sc < SW'(FREE_DEPTH)) begin
                    sh_we = 1'b1;
                    n_sc  = r_sc + SW'(1);
                end else begin
                    n_status = ST_OVF;
                end
                n_addr = (r_addr + HandleW'(sz)) & HMASK;
                n_off  = off_nxt;
                if (off_nxt + OW'(sz) > OW'(PAGE_BYTES)) begin
                    n_state = S_RF_RD;
                end
            end
            S_RF_RD: begin
                if (cnt_cur < CNW'(BMIN) && r_sc != '0) begin
                    sh_re   = 1'b1;
                    n_sc    = r_sc - SW'(1);
                    n_state = S_RF_WR;
                end else if (cnt_cur != '0) begin
                    cpu_re   = 1'b1;
                    cnt_we   = 1'b1;
                    cnt_wd   = cnt_cur - CNW'(1);
                    n_use_rd = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    n_status = ST_OOM;
                    n_state  = S_FIN;
                end
            end
            S_RF_WR: begin
                cpu_we  = 1'b1;
                cpu_wd  = r_sh_rd;
                cnt_we  = 1'b1;
                cnt_wd  = cnt_cur + CNW'(1);
                n_moved = r_moved + MovedW'(1);
                n_state = S_RF_RD;
            end
            S_FL_RD: begin
                if (r_i < IW'(BATCH) && cnt_cur != '0) begin
                    cpu_re  = 1'b1;
                    cnt_we  = 1'b1;
                    cnt_wd  = cnt_cur - CNW'(1);
                    n_i     = r_i + IW'(1);
                    n_state = S_FL_WR;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_FL_WR: begin
                sh_wd = r_cpu_rd;
                if (r_sc < SW'(FREE_DEPTH)) begin
                    sh_we = 1'b1;
                    n_sc  = r_sc + SW'(1);
                end else begin
                    n_status = ST_OVF;
                end
                n_moved = r_moved - MovedW'(1);
                n_state = S_FL_RD;
            end
            S_PUSH: begin
                if (cnt_cur < CNW'(LIMIT)) begin
                    cpu_we = 1'b1;
                    cnt_we = 1'b1;
                    cnt_wd = cnt_cur + CNW'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cpu_we) begin
            cpu_mem[cpu_wa] <= cpu_wd;
        end
        if (cpu_re) begin
            r_cpu_rd <= cpu_mem[cpu_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            sh_mem[sh_wa] <= sh_wd;
        end
        if (sh_re) begin
            r_sh_rd <= sh_mem[sh_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_obj_bytes <= ObjBytesRst;
            r_sc        <= '0;
            r_moved     <= '0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < CPUS; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sc    <= n_sc;
            r_moved <= n_moved;
            if (i_cfg_we) begin
                r_obj_bytes <= i_cfg_data;
            end
            if (cnt_we) begin
                r_counts[cpu_cur] <= cnt_wd;
            end
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpu    <= n_cpu;
        r_obj    <= n_obj;
        r_status <= n_status;
        r_taken  <= n_taken;
        r_off    <= n_off;
        r_addr   <= n_addr;
        r_i      <= n_i;
        r_use_rd <= n_use_rd;
        if (fin_load) begin
            r_ohandle <= r_use_rd ? r_cpu_rd : '0;
            r_ostatus <= r_status;
            r_otaken  <= r_taken;
            r_ofree   <= FreeOutW'(r_sc);
            r_omoved  <= r_moved;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_handle        = r_ohandle;
    assign o_status        = r_ostatus;
    assign o_page_taken    = r_otaken;
    assign o_free_objects  = r_ofree;
    assign o_moved_objects = r_omoved;

    a_sc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= SW'(FREE_DEPTH))
        else $error("shared stack count beyond depth");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_cur <= CNW'(LIMIT))
        else $error("cpu stack count beyond limit");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && i_stall) |=> (r_state == S_FIN))
        else $error("result dropped while output stalled");

    a_taken_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_taken) |-> (o_status == ST_OK || o_status == ST_OVF))
        else $error("page taken with bad status");

endmodule

@@ bench/slab_object_allocator_test.sv @@
module slab_object_allocator_test;
    import slab_pkg::*;

    // Bench view of one result item, laid out like the output ports.
    typedef struct {
        logic [HandleW-1:0]  handle;
        t_status             status;
        logic                page_taken;
        logic [FreeOutW-1:0] free_objects;
        logic [MovedW-1:0]   moved_objects;
    } t_slab_result;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [ObjBytesW-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_cmd;
    logic [CpuIdxW-1:0]   i_cpu_index;
    logic [HandleW-1:0]   i_obj_handle;
    logic [HandleW-1:0]   i_page_base;
    logic                 i_page_valid;
    logic                 o_valid;
    logic                 i_stall;
    logic [HandleW-1:0]   o_handle;
    logic [1:0]           o_status;
    logic                 o_page_taken;
    logic [FreeOutW-1:0]  o_free_objects;
    logic [MovedW-1:0]    o_moved_objects;

    slab_object_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_cpu_index     (i_cpu_index),
        .i_obj_handle    (i_obj_handle),
        .i_page_base     (i_page_base),
        .i_page_valid    (i_page_valid),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_handle        (o_handle),
        .o_status        (o_status),
        .o_page_taken    (o_page_taken),
        .o_free_objects  (o_free_objects),
        .o_moved_objects (o_moved_objects)
    );

    // Mirror of the cache state. Only entries below the live counts are ever
    // read, so the stack arrays need no clearing.
    logic [HandleW-1:0]   shared_stack [FreeDepthDef];
    int unsigned          shared_count;
    logic [HandleW-1:0]   cpu_stack [CpusDef][LimitDef];
    int unsigned          cpu_count [CpusDef];
    logic [MovedW-1:0]    moved_count;
    logic [ObjBytesW-1:0] object_size;

    t_slab_result         pending_results [$];
    logic [HandleW-1:0]   live_handles [$];
    int unsigned          error_count;
    int unsigned          cycle_count;

    // Receiver controls: a stall chance in percent, and a forced hold-off
    // that the receiver process counts down on its own.
    int unsigned          stall_percent;
    int unsigned          hold_request;
    // When set, the sender offers items back to back.
    bit                   sender_busy;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        error_count++;
    endtask

    // One allocate or free applied to the mirrored state. This follows the
    // cache exactly, including the quiet cases: bad CPU numbers fold onto
    // CPU 0, small object sizes count as 8 bytes, and carved addresses wrap
    // at the handle width.
    function automatic t_slab_result slab_predict(input logic cmd, input logic [7:0] cpu_in,
                                                  input logic [HandleW-1:0] obj,
                                                  input logic [HandleW-1:0] page,
                                                  input logic page_ok);
        t_slab_result r;
        int unsigned cpu;
        int unsigned size;
        int unsigned objs;
        logic [HandleW-1:0] addr;
        r.handle = '0;
        r.status = ST_OK;
        r.page_taken = 1'b0;
        cpu = (32'(cpu_in) >= CpusDef) ? 0 : 32'(cpu_in);
        if (cmd == CMD_ALLOC) begin
            if (cpu_count[cpu] == 0) begin
                if (shared_count == 0) begin
                    size = (object_size < ObjBytesMin) ? 32'(ObjBytesMin) : 32'(object_size);
                    objs = PageBytesDef / size;
                    if (page_ok && objs > 0) begin
                        r.page_taken = 1'b1;
                        for (int unsigned i = 0; i < objs; i++) begin
                            addr = page + HandleW'(i * size);
                            if (shared_count >= FreeDepthDef) begin
                                r.status = ST_OVF;
                            end else begin
                                shared_stack[shared_count] = addr;
                                shared_count++;
                            end
                        end
                    end
                end
                while (cpu_count[cpu] < BatchDef && cpu_count[cpu] < LimitDef
                       && shared_count > 0) begin
                    shared_count--;
                    cpu_stack[cpu][cpu_count[cpu]] = shared_stack[shared_count];
                    cpu_count[cpu]++;
                    moved_count = moved_count + 1'b1;
                end
            end
            if (cpu_count[cpu] > 0) begin
                cpu_count[cpu]--;
                r.handle = cpu_stack[cpu][cpu_count[cpu]];
            end else begin
                r.status = ST_OOM;
            end
        end else if (obj == '0) begin
            r.status = ST_NULL;
        end else begin
            // A full CPU stack first spills one batch to the shared stack;
            // whatever does not fit there is lost.
            if (cpu_count[cpu] >= LimitDef) begin
                for (int unsigned i = 0; i < BatchDef && cpu_count[cpu] > 0; i++) begin
                    cpu_count[cpu]--;
                    if (shared_count >= FreeDepthDef) begin
                        r.status = ST_OVF;
                    end else begin
                        shared_stack[shared_count] = cpu_stack[cpu][cpu_count[cpu]];
                        shared_count++;
                    end
                    moved_count = moved_count - 1'b1;
                end
            end
            if (cpu_count[cpu] < LimitDef) begin
                cpu_stack[cpu][cpu_count[cpu]] = obj;
                cpu_count[cpu]++;
            end
        end
        r.free_objects = FreeOutW'(shared_count);
        r.moved_objects = moved_count;
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one item and waits until it is taken. The expectation is made
    // at the accepting edge, so the mirror follows acceptance order.
    task automatic send_item(input logic cmd, input logic [7:0] cpu,
                             input logic [HandleW-1:0] obj, input logic [HandleW-1:0] page,
                             input logic page_ok);
        int unsigned gap;
        t_slab_result r;
        gap = sender_busy ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_cpu_index  <= cpu;
        i_obj_handle <= obj;
        i_page_base  <= page;
        i_page_valid <= page_ok;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        r = slab_predict(cmd, cpu, obj, page, page_ok);
        pending_results.push_back(r);
        if (cmd == CMD_ALLOC && r.status != ST_OOM && r.handle != '0)
            live_handles.push_back(r.handle);
    endtask

    // Lowers valid and waits until every result is back, plus a margin for
    // any work still trailing inside the block.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_object_size(input logic [ObjBytesW-1:0] size);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        object_size = size;
    endtask

    function automatic logic [HandleW-1:0] random_address();
        return HandleW'({$urandom(), $urandom()});
    endfunction

    // Result checker: an item leaves the block at a rising edge where
    // o_valid is high and i_stall is low.
    always @(posedge i_clk) begin
        t_slab_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(o_handle), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_handle !== want.handle)
                    report_mismatch("handle", 64'(o_handle), 64'(want.handle));
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_page_taken !== want.page_taken)
                    report_mismatch("page_taken", 64'(o_page_taken), 64'(want.page_taken));
                if (o_free_objects !== want.free_objects)
                    report_mismatch("free_objects", 64'(o_free_objects),
                                    64'(want.free_objects));
                if (o_moved_objects !== want.moved_objects)
                    report_mismatch("moved_objects", 64'(o_moved_objects),
                                    64'(want.moved_objects));
            end
        end
    end

    // Receiver stall driver. Besides single-cycle stalls it now and then
    // starts a longer burst; a hold request from a test overrides both.
    initial begin
        int unsigned burst;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_request--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (stall_percent > 0 && $urandom_range(0, 199) == 0) begin
                burst = $urandom_range(10, 50);
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_percent);
            end
        end
    end

    // Edge values: an empty cache with and without a page, a page at address
    // zero, a page that wraps past the top of the handle space, a bad CPU,
    // the largest and the degenerate object sizes, null and all-ones frees.
    task automatic test_directed();
        write_object_size(12'd2048);
        send_item(CMD_ALLOC, 8'd0, '0, random_address(), 1'b0);
        send_item(CMD_ALLOC, 8'd0, '0, '0, 1'b1);
        send_item(CMD_ALLOC, 8'd0, '0, random_address(), 1'b1);
        send_item(CMD_ALLOC, 8'd1, '0, {HandleW{1'b1}} - 48'h7FF, 1'b1);
        send_item(CMD_ALLOC, 8'd1, '0, '0, 1'b0);
        write_object_size(12'd4095);
        send_item(CMD_ALLOC, 8'd255, '0, {HandleW{1'b1}}, 1'b1);
        send_item(CMD_ALLOC, 8'd4, '0, random_address(), 1'b1);
        write_object_size(12'd0);
        send_item(CMD_ALLOC, 8'd2, '0, 48'h0000_1000_0000, 1'b1);
        send_item(CMD_ALLOC, 8'd3, '0, '0, 1'b0);
        write_object_size(12'd5);
        send_item(CMD_FREE, 8'd2, '0, random_address(), 1'b1);
        send_item(CMD_FREE, 8'd2, {HandleW{1'b1}}, '0, 1'b0);
        send_item(CMD_FREE, 8'd128, 48'h1, random_address(), 1'b1);
        send_item(CMD_FREE, 8'd3, 48'h8000_0000_0000, '0, 1'b0);
        send_item(CMD_ALLOC, 8'd3, '0, '0, 1'b0);
        send_item(CMD_ALLOC, 8'd2, '0, '0, 1'b0);
        send_item(CMD_ALLOC, 8'd0, '0, random_address(), 1'b0);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills up and stalls its input.
    task automatic test_backpressure();
        write_object_size(12'd32);
        sender_busy = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 5)), random_address(),
                      random_address(), 1'b1);
        sender_busy = 1'b0;
        drain_results();
    endtask

    // Frees flood the CPU stacks until spilled batches overflow the shared
    // stack, then a few allocations take some of it back out.
    task automatic test_shared_overflow();
        write_object_size(12'd64);
        for (int i = 0; i < 1200; i++)
            send_item(CMD_FREE, 8'($urandom_range(0, 3)), random_address() | 48'h1, '0, 1'b0);
        for (int i = 0; i < 50; i++)
            send_item(CMD_ALLOC, 8'($urandom_range(0, 3)), '0, random_address(), 1'b1);
        live_handles.delete();
    endtask

    // Allocations and frees in phases, one object size per phase. Most
    // frees return handles that were handed out earlier.
    task automatic test_random_traffic();
        logic [ObjBytesW-1:0] sizes [6];
        logic [HandleW-1:0] obj;
        int unsigned pick;
        sizes = '{12'd8, 12'd4095, 12'd32, 12'd0, 12'd256, 12'd0};
        sizes[5] = ObjBytesW'($urandom_range(0, 4095));
        for (int phase = 0; phase < 6; phase++) begin
            write_object_size(sizes[phase]);
            // One phase runs with a receiver that never stalls.
            stall_percent = (phase == 2) ? 0 : $urandom_range(10, 40);
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(0, 99) < 50) begin
                    send_item(CMD_ALLOC, 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                        : $urandom_range(0, 3)),
                              random_address(), random_address(),
                              $urandom_range(0, 9) != 0);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70 && live_handles.size() > 0) begin
                        pick = $urandom_range(0, live_handles.size() - 1);
                        obj = live_handles[pick];
                        live_handles.delete(pick);
                    end else if (pick < 80) begin
                        obj = '0;
                    end else begin
                        obj = random_address();
                    end
                    send_item(CMD_FREE, 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                       : $urandom_range(0, 3)),
                              obj, random_address(), 1'($urandom_range(0, 1)));
                end
            end
        end
        stall_percent = 20;
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        stall_percent = 20;
        hold_request  = 0;
        sender_busy   = 1'b0;
        shared_count  = 0;
        moved_count   = '0;
        object_size   = ObjBytesRst;
        for (int c = 0; c < CpusDef; c++) cpu_count[c] = 0;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_cmd        = CMD_ALLOC;
        i_cpu_index  = '0;
        i_obj_handle = '0;
        i_page_base  = '0;
        i_page_valid = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_traffic();
        test_shared_overflow();

        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
